FILE: sv/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants and widths for the bicubic image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

    // default store geometry and step format
    localparam int DEF_MAX_WIDTH      = 512;
    localparam int DEF_MAX_HEIGHT     = 512;
    localparam int DEF_STEP_FRAC_BITS = 16;

    // fixed field widths
    localparam int POS_W   = 12;
    localparam int PIX_W   = 8;
    localparam int DIM_W   = 10;
    localparam int STEP_W  = 24;
    localparam int OUT_W   = 16;
    localparam int PHASE_W = 8;
    localparam int SX_W    = POS_W + STEP_W;

    // cubic unit widths: sample in, accumulator out
    localparam int SMP_W = 20;
    localparam int ACC_W = 52;

    // configuration register indexes
    localparam logic [1:0] REG_IN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_X_STEP    = 2'd2;
    localparam logic [1:0] REG_Y_STEP    = 2'd3;

    // request modes
    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

endpackage

FILE: sv/bicubic_image_scaler_top.sv
// ----------------------------------------------------------------------------
// bicubic_image_scaler_top
// Frame store with bicubic (Catmull-Rom) resampling of output pixels.
// ----------------------------------------------------------------------------
// A write word (tuser 0) inside the frame stores one pixel and yields no
// output. A request word (tuser 1) runs the step multiply and range check,
// then four source rows, then the vertical cubic pass and the hand-off; no
// new input word is taken until its result is handed to the output register.
// Each row is four serial reads of the frame memory plus a pass of the
// shared cubic unit. A request whose source falls outside the frame skips the
// reads and the cubic passes and goes straight to the hand-off. The frame
// memory read port and the one shared cubic unit set this serial order.
// Writes are taken while a finished result still waits on the master side.
// The frame memory has no reset; pixels must be written before they are used.
// ----------------------------------------------------------------------------
module bicubic_image_scaler_top
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int STEP_FRAC_BITS = DEF_STEP_FRAC_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [STEP_W-1:0] cfg_data,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // pos_x[11:0], pos_y[23:12], pixel_in[31:24]
    input  logic              s_tuser,   // mode
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // pixel_out[15:0]
    output logic              m_tuser    // out_of_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int IX_W  = SX_W - STEP_FRAC_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_HGO   = 4'd5;
    localparam logic [3:0] S_HRUN  = 4'd6;
    localparam logic [3:0] S_VGO   = 4'd7;
    localparam logic [3:0] S_VRUN  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // configuration registers
    logic [DIM_W-1:0]  in_width_reg, in_height_reg;
    logic [STEP_W-1:0] x_step_reg, y_step_reg;
    logic [DIM_W-1:0]  w_eff, h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg  <= DIM_W'(512);
            in_height_reg <= DIM_W'(512);
            x_step_reg    <= STEP_W'(65536);
            y_step_reg    <= STEP_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_WIDTH:  in_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IN_HEIGHT: in_height_reg <= cfg_data[DIM_W-1:0];
                REG_X_STEP:    x_step_reg    <= cfg_data;
                REG_Y_STEP:    y_step_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // clamp size to the store
    assign w_eff = (32'(in_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : in_width_reg;
    assign h_eff = (32'(in_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : in_height_reg;

    // input word fields
    logic [POS_W-1:0] in_x, in_y;
    logic [PIX_W-1:0] in_pix;
    logic             s_acc;

    assign in_x   = s_tdata[POS_W-1:0];
    assign in_y   = s_tdata[2*POS_W-1:POS_W];
    assign in_pix = s_tdata[2*POS_W+PIX_W-1:2*POS_W];

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // frame memory
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [PIX_W-1:0] mem_rdata;

    assign mem_we    = s_acc && (s_tuser == MODE_WRITE) &&
                       (in_x < POS_W'(w_eff)) && (in_y < POS_W'(h_eff));
    assign mem_waddr = AW'(32'(in_y) * MAX_WIDTH + 32'(in_x));

    bis_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_pix),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // request datapath registers
    logic [POS_W-1:0]  px_reg, py_reg;
    logic [SX_W-1:0]   sx_reg, sy_reg;
    logic [DIM_W-1:0]  cols_reg [4];
    logic [DIM_W-1:0]  rows_reg [4];
    logic [PHASE_W-1:0] tx_reg, ty_reg;
    logic [1:0]        k_reg, j_reg;
    logic              rd_vld_reg;
    logic [1:0]        rd_idx_reg;
    logic [PIX_W-1:0]  p_reg [4];
    logic signed [SMP_W-1:0] r_reg [4];
    logic              oor_reg;
    logic signed [OUT_W-1:0] res_reg;

    logic [IX_W-1:0]   ix, iy;
    logic              out_rng;
    logic [DIM_W:0]    ix1, ix2, iy1, iy2;

    assign ix      = sx_reg[SX_W-1:STEP_FRAC_BITS];
    assign iy      = sy_reg[SX_W-1:STEP_FRAC_BITS];
    assign out_rng = (ix >= IX_W'(w_eff)) || (iy >= IX_W'(h_eff));
    assign ix1     = {1'b0, ix[DIM_W-1:0]} + (DIM_W+1)'(1);
    assign ix2     = {1'b0, ix[DIM_W-1:0]} + (DIM_W+1)'(2);
    assign iy1     = {1'b0, iy[DIM_W-1:0]} + (DIM_W+1)'(1);
    assign iy2     = {1'b0, iy[DIM_W-1:0]} + (DIM_W+1)'(2);

    assign mem_raddr = AW'(32'(rows_reg[j_reg]) * MAX_WIDTH + 32'(cols_reg[k_reg]));

    // shared cubic unit
    logic                    cub_start, cub_done;
    logic signed [SMP_W-1:0] cp0, cp1, cp2, cp3;
    logic [PHASE_W-1:0]      ct;
    logic signed [ACC_W-1:0] cub_h;
    logic signed [SMP_W-1:0] row_val;
    logic signed [ACC_W-27:0] v_full;

    assign cub_start = (state_reg == S_HGO) || (state_reg == S_VGO);
    assign cp0 = (state_reg == S_VGO) ? r_reg[0] : SMP_W'(p_reg[0]);
    assign cp1 = (state_reg == S_VGO) ? r_reg[1] : SMP_W'(p_reg[1]);
    assign cp2 = (state_reg == S_VGO) ? r_reg[2] : SMP_W'(p_reg[2]);
    assign cp3 = (state_reg == S_VGO) ? r_reg[3] : SMP_W'(p_reg[3]);
    assign ct  = (state_reg == S_VGO) ? ty_reg : tx_reg;

    bis_cubic u_cubic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cub_start),
        .p0    (cp0),
        .p1    (cp1),
        .p2    (cp2),
        .p3    (cp3),
        .t     (ct),
        .done  (cub_done),
        .h     (cub_h)
    );

    // round half up: row to 1/256 level, final to 1/64 level
    assign row_val = SMP_W'((cub_h + ACC_W'(65536)) >>> 17);
    assign v_full  = (ACC_W-26)'((cub_h + ACC_W'(67108864)) >>> 27);

    // output register
    logic out_free;
    logic m_tvalid_reg;
    logic [OUT_W-1:0] m_data_reg;
    logic m_user_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_acc && (s_tuser == MODE_REQUEST)) state_next = S_MUL;
            S_MUL:   state_next = S_CHK;
            S_CHK:   state_next = out_rng ? S_DONE : S_READ;
            S_READ:  if (k_reg == 2'd3) state_next = S_WAIT;
            S_WAIT:  state_next = S_HGO;
            S_HGO:   state_next = S_HRUN;
            S_HRUN:  if (cub_done) state_next = (j_reg == 2'd3) ? S_VGO : S_READ;
            S_VGO:   state_next = S_VRUN;
            S_VRUN:  if (cub_done) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= 2'd0;
            j_reg      <= 2'd0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == S_READ);
            if (state_reg == S_CHK)
            begin
                k_reg <= 2'd0;
                j_reg <= 2'd0;
            end
            else if (state_reg == S_READ)
            begin
                k_reg <= k_reg + 2'd1;
            end
            else if ((state_reg == S_HRUN) && cub_done)
            begin
                j_reg <= j_reg + 2'd1;
            end
        end
    end

    // request datapath
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= k_reg;
        if (rd_vld_reg)
        begin
            p_reg[rd_idx_reg] <= mem_rdata;
        end
        case (state_reg)
            S_IDLE:
            begin
                px_reg <= in_x;
                py_reg <= in_y;
            end
            S_MUL:
            begin
                sx_reg <= SX_W'(px_reg * x_step_reg);
                sy_reg <= SX_W'(py_reg * y_step_reg);
            end
            S_CHK:
            begin
                // edge-replicated tap positions
                cols_reg[1] <= ix[DIM_W-1:0];
                cols_reg[0] <= (ix[DIM_W-1:0] == '0) ? ix[DIM_W-1:0] : ix[DIM_W-1:0] - 1'b1;
                cols_reg[2] <= (ix1 < {1'b0, w_eff}) ? ix1[DIM_W-1:0] : ix[DIM_W-1:0];
                cols_reg[3] <= (ix2 < {1'b0, w_eff}) ? ix2[DIM_W-1:0] :
                               (ix1 < {1'b0, w_eff}) ? ix1[DIM_W-1:0] : ix[DIM_W-1:0];
                rows_reg[1] <= iy[DIM_W-1:0];
                rows_reg[0] <= (iy[DIM_W-1:0] == '0) ? iy[DIM_W-1:0] : iy[DIM_W-1:0] - 1'b1;
                rows_reg[2] <= (iy1 < {1'b0, h_eff}) ? iy1[DIM_W-1:0] : iy[DIM_W-1:0];
                rows_reg[3] <= (iy2 < {1'b0, h_eff}) ? iy2[DIM_W-1:0] :
                               (iy1 < {1'b0, h_eff}) ? iy1[DIM_W-1:0] : iy[DIM_W-1:0];
                tx_reg      <= sx_reg[STEP_FRAC_BITS-1 -: PHASE_W];
                ty_reg      <= sy_reg[STEP_FRAC_BITS-1 -: PHASE_W];
                oor_reg     <= out_rng;
                res_reg     <= '0;
            end
            S_HRUN:
            begin
                if (cub_done)
                begin
                    r_reg[j_reg] <= row_val;
                end
            end
            S_VRUN:
            begin
                // saturate to 16 bits signed
                if (cub_done)
                begin
                    if (v_full > (ACC_W-26)'(32767))
                        res_reg <= 16'sh7FFF;
                    else if (v_full < -(ACC_W-26)'(32768))
                        res_reg <= 16'sh8000;
                    else
                        res_reg <= OUT_W'(v_full);
                end
            end
            default: ;
        endcase
    end

    // master-side word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            m_data_reg <= res_reg;
            m_user_reg <= oor_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: sv/bis_frame_mem.sv
// ----------------------------------------------------------------------------
// bis_frame_mem
// Source frame store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bis_frame_mem
    import bis_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [PIX_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [PIX_W-1:0] rdata
);

    logic [PIX_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/bis_cubic.sv
// ----------------------------------------------------------------------------
// bis_cubic
// Iterative Catmull-Rom cubic: H = t(t(At + 256B) + 65536C) + 2^24 D,
// one multiply-add per cycle while busy; done pulses when H is complete.
// ----------------------------------------------------------------------------
module bis_cubic
    import bis_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SMP_W-1:0] p0,
    input  logic signed [SMP_W-1:0] p1,
    input  logic signed [SMP_W-1:0] p2,
    input  logic signed [SMP_W-1:0] p3,
    input  logic [PHASE_W-1:0]      t,
    output logic                    done,
    output logic signed [ACC_W-1:0] h
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] b_reg;
    logic signed [ACC_W-1:0] c_reg;
    logic signed [ACC_W-1:0] d_reg;
    logic signed [PHASE_W:0] t_reg;
    logic [1:0]              cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic signed [ACC_W-1:0] e0, e1, e2, e3;
    logic signed [ACC_W-1:0] addend;

    assign e0 = ACC_W'(p0);
    assign e1 = ACC_W'(p1);
    assign e2 = ACC_W'(p2);
    assign e3 = ACC_W'(p3);

    // addend per step: 256B, 65536C, 2^24 D
    always_comb
    begin
        case (cnt_reg)
            2'd0:    addend = b_reg <<< 8;
            2'd1:    addend = c_reg <<< 16;
            default: addend = d_reg <<< 24;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= (e1 <<< 1) + e1 + e3 - e0 - ((e2 <<< 1) + e2);
            b_reg   <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
            c_reg   <= e2 - e0;
            d_reg   <= e1 <<< 1;
            t_reg   <= $signed({1'b0, t});
        end
        else if (busy_reg)
        begin
            acc_reg <= ACC_W'(acc_reg * t_reg) + addend;
        end
    end

    assign done = done_reg;
    assign h    = acc_reg;

endmodule

FILE: tb/bis_checker.sv
// ----------------------------------------------------------------------------
// bis_checker
// Watches the config port and both streams of the bicubic scaler, keeps its
// own copy of the frame and the scale settings, predicts every output pixel
// and compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module bis_checker
    import bis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [STEP_W-1:0] cfg_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [15:0]       m_tdata,
    input  logic              m_tuser,
    output int                errors,
    output int                pending
);

    typedef struct packed {
        logic [OUT_W-1:0] level;
        logic             oor;
    } scaled_px_t;

    // shadow copy of the scaler state
    logic [PIX_W-1:0]  frame_px [int];
    logic [DIM_W-1:0]  sh_width;
    logic [DIM_W-1:0]  sh_height;
    logic [STEP_W-1:0] sh_xstep;
    logic [STEP_W-1:0] sh_ystep;
    scaled_px_t        scaled_q [$];

    function automatic longint px_at(int row, int col);
        int idx;
        idx = row * DEF_MAX_WIDTH + col;
        return frame_px.exists(idx) ? longint'(frame_px[idx]) : 0;
    endfunction

    // Catmull-Rom cubic, phase t in 1/256 steps
    function automatic longint catmull(longint p0, longint p1, longint p2,
                                       longint p3, longint t);
        longint a, b, c, d;
        a = -p0 + 3 * p1 - 3 * p2 + p3;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = p2 - p0;
        d = 2 * p1;
        return t * (t * (a * t + b * 256) + c * 65536) + d * 64'sd16777216;
    endfunction

    // round half up then drop k bits (floor of v/2^k + 1/2)
    function automatic longint round_drop(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    // horizontal pass over one source row
    function automatic longint row_level(int row, int ix, longint t, int w);
        longint p0, p1, p2, p3;
        p1 = px_at(row, ix);
        p0 = (ix >= 1) ? px_at(row, ix - 1) : p1;
        p2 = (ix + 1 < w) ? px_at(row, ix + 1) : p1;
        p3 = (ix + 2 < w) ? px_at(row, ix + 2) : p2;
        return round_drop(catmull(p0, p1, p2, p3, t), 17);
    endfunction

    function automatic scaled_px_t scale_pixel(int px, int py);
        scaled_px_t res;
        int         w, h, ix, iy;
        longint     sx, sy, tx, ty, r0, r1, r2, r3, v;
        w  = (sh_width  > DEF_MAX_WIDTH)  ? DEF_MAX_WIDTH  : int'(sh_width);
        h  = (sh_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(sh_height);
        sx = longint'(px) * longint'(sh_xstep);
        sy = longint'(py) * longint'(sh_ystep);
        res.level = '0;
        res.oor   = 1'b1;
        if ((sx >> DEF_STEP_FRAC_BITS) >= w || (sy >> DEF_STEP_FRAC_BITS) >= h)
            return res;
        ix = int'(sx >> DEF_STEP_FRAC_BITS);
        iy = int'(sy >> DEF_STEP_FRAC_BITS);
        tx = (sx & 64'hFFFF) >> (DEF_STEP_FRAC_BITS - PHASE_W);
        ty = (sy & 64'hFFFF) >> (DEF_STEP_FRAC_BITS - PHASE_W);
        r1 = row_level(iy, ix, tx, w);
        r0 = (iy >= 1) ? row_level(iy - 1, ix, tx, w) : r1;
        r2 = (iy + 1 < h) ? row_level(iy + 1, ix, tx, w) : r1;
        r3 = (iy + 2 < h) ? row_level(iy + 2, ix, tx, w) : r2;
        v  = round_drop(catmull(r0, r1, r2, r3, ty), 27);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        res.level = v[15:0];
        res.oor   = 1'b0;
        return res;
    endfunction

    assign pending = scaled_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        scaled_px_t exp_px;
        int         wx, wy, ew, eh;
        int         n_err;
        if (!rst_n)
        begin
            sh_width  <= 10'd512;
            sh_height <= 10'd512;
            sh_xstep  <= 24'd65536;
            sh_ystep  <= 24'd65536;
            errors    <= 0;
            scaled_q.delete();
        end
        else
        begin
            n_err = 0;
            // config writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IN_WIDTH:  sh_width  <= cfg_data[DIM_W-1:0];
                    REG_IN_HEIGHT: sh_height <= cfg_data[DIM_W-1:0];
                    REG_X_STEP:    sh_xstep  <= cfg_data;
                    REG_Y_STEP:    sh_ystep  <= cfg_data;
                    default: ;
                endcase
            end
            // accepted input word
            if (s_tvalid && s_tready)
            begin
                wx = int'(s_tdata[11:0]);
                wy = int'(s_tdata[23:12]);
                if (s_tuser == MODE_WRITE)
                begin
                    ew = (sh_width  > DEF_MAX_WIDTH)  ? DEF_MAX_WIDTH  : int'(sh_width);
                    eh = (sh_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(sh_height);
                    if (wx < ew && wy < eh)
                        frame_px[wy * DEF_MAX_WIDTH + wx] = s_tdata[31:24];
                end
                else
                    scaled_q.push_back(scale_pixel(wx, wy));
            end
            // accepted output word
            if (m_tvalid && m_tready)
            begin
                if (scaled_q.size() == 0)
                begin
                    $error("output word with nothing expected: pixel_out=%0d", $signed(m_tdata));
                    n_err = n_err + 1;
                end
                else
                begin
                    exp_px = scaled_q.pop_front();
                    if (m_tdata !== exp_px.level)
                    begin
                        $error("pixel_out: expected %0d, got %0d",
                               $signed(exp_px.level), $signed(m_tdata));
                        n_err = n_err + 1;
                    end
                    if (m_tuser !== exp_px.oor)
                    begin
                        $error("out_of_range: expected %0b, got %0b", exp_px.oor, m_tuser);
                        n_err = n_err + 1;
                    end
                end
            end
            if (n_err != 0)
                errors <= errors + n_err;
        end
    end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bicubic scaler: each phase sets frame size and both
// steps, fills the whole frame, then asks for output pixels, mostly inside
// the frame. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
    import bis_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [STEP_W-1:0] cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // pos_x[11:0], pos_y[23:12], pixel_in[31:24]
    logic              s_tuser;   // mode
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;   // pixel_out[15:0]
    logic              m_tuser;   // out_of_range
    int                errors;
    int                pending;

    int n_items;
    int n_writes;
    int n_requests;
    int n_phases;
    int burst_left;
    int stall_style;
    int stall_cnt;

    bicubic_image_scaler_top dut (.*);

    bis_checker chk (.*);

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // timeout
    initial
    begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver stall pattern; a random one of four styles, changed when its count runs out
    always @(negedge clk)
    begin
        if (stall_cnt == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_cnt   = $urandom_range(100, 400);
        end
        stall_cnt = stall_cnt - 1;
        case (stall_style)
            0:       m_tready = 1'b1;
            1:       m_tready = ($urandom_range(0, 1) == 1);
            2:       m_tready = ($urandom_range(0, 15) == 0);
            default: m_tready = ((stall_cnt % 37) > 25);
        endcase
    end

    task automatic cfg_write(logic [1:0] idx, logic [STEP_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // one word on the input stream, with bursts and gaps
    task automatic send_word(logic mode, int x, int y, int level);
        logic ok;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {level[7:0], y[11:0], x[11:0]};
        ok = 1'b0;
        while (!ok)
        begin
            #1;
            ok = s_tready;
            @(negedge clk);
        end
        s_tvalid = 1'b0;
        s_tdata  = $urandom;
        n_items  = n_items + 1;
        if (mode == MODE_WRITE)
            n_writes = n_writes + 1;
        else
            n_requests = n_requests + 1;
    endtask

    // hold the sender until every result is back, then let the block settle
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // largest output coordinate whose source still falls inside the frame
    function automatic int in_lim(int dim, int step);
        longint lim;
        if (dim > 512)
            dim = 512;
        if (step == 0)
            return 4095;
        lim = ((longint'(dim) << 16) - 1) / step;
        return (lim > 4095) ? 4095 : int'(lim);
    endfunction

    task automatic run_phase(int w, int h, int xs, int ys, int nreq);
        int ew, eh, lx, ly, lvl, x, y;
        drain();
        cfg_write(REG_IN_WIDTH, w);
        cfg_write(REG_IN_HEIGHT, h);
        cfg_write(REG_X_STEP, xs);
        cfg_write(REG_Y_STEP, ys);
        n_phases = n_phases + 1;
        ew = (w > 512) ? 512 : w;
        eh = (h > 512) ? 512 : h;
        // fill the whole frame, levels lean toward the extremes
        for (int r = 0; r < eh; r++)
            for (int c = 0; c < ew; c++)
            begin
                case ($urandom_range(0, 4))
                    0:       lvl = 0;
                    1:       lvl = 255;
                    default: lvl = $urandom_range(0, 255);
                endcase
                send_word(MODE_WRITE, c, r, lvl);
            end
        // a few writes outside the frame, which must be dropped
        repeat (3)
        begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
            if (x < ew && y < eh)
                x = ew + $urandom_range(0, 4095 - ew);
            send_word(MODE_WRITE, x, y, $urandom_range(0, 255));
        end
        if (ew == 0 || eh == 0)
            ew = 0;
        lx = in_lim(ew, xs);
        ly = in_lim(eh, ys);
        // corners first, then mostly in-frame requests
        send_word(MODE_REQUEST, 0, 0, $urandom_range(0, 255));
        send_word(MODE_REQUEST, lx, ly, $urandom_range(0, 255));
        send_word(MODE_REQUEST, 4095, 4095, $urandom_range(0, 255));
        for (int i = 0; i < nreq; i++)
        begin
            if ($urandom_range(0, 4) == 0 || ew == 0)
            begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end
            else
            begin
                x = $urandom_range(0, lx);
                y = $urandom_range(0, ly);
            end
            send_word(MODE_REQUEST, x, y, $urandom_range(0, 255));
        end
    endtask

    function automatic int pick_step();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return 24'hFFFFFF;
            2:       return 0;
            3:       return 24'h10000;
            4:       return $urandom_range(24'h100, 24'hFFFFFF);
            default: return $urandom_range(24'h2000, 24'h30000);
        endcase
    endfunction

    initial
    begin
        int w, h;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_IN_WIDTH;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_WRITE;
        m_tready    = 1'b0;
        stall_cnt   = 0;
        stall_style = 0;
        burst_left  = 0;
        n_items     = 0;
        n_writes    = 0;
        n_requests  = 0;
        n_phases    = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: unit step, half phase, near-full phase, zero step,
        // zero size, oversize width clamped to the store
        run_phase(4, 4, 24'h10000, 24'h10000, 2);
        run_phase(4, 4, 24'h08000, 24'h0FFFF, 2);
        run_phase(3, 2, 24'h0, 24'h0, 1);
        run_phase(0, 4, 24'h10000, 24'h10000, 2);
        run_phase(1023, 1, 24'hFFFFFF, 24'h1, 2);

        // random phases, mostly tiny frames, a few wide or tall ones
        while (n_items < 1150)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    w = 512;
                    h = $urandom_range(1, 2);
                end
                1:
                begin
                    w = $urandom_range(1, 2);
                    h = $urandom_range(500, 1023);
                end
                2:
                begin
                    w = $urandom_range(0, 1);
                    h = $urandom_range(0, 3);
                end
                default:
                begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 8);
                end
            endcase
            // a large fill must not overshoot the item budget
            if (((w > 512) ? 512 : w) * ((h > 512) ? 512 : h) > 1150 - n_items)
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
            end
            run_phase(w, h, pick_step(), pick_step(), $urandom_range(10, 40));
        end

        drain();
        $display("covered %0d pixel writes and %0d scaled-pixel requests", n_writes, n_requests);
        $display("over %0d frame size and step settings", n_phases);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
